### hdl/dta_pkg.sv
// dta_pkg: shared types, constants and tables of the double to ASCII formatter.
// No dependencies.
package dta_pkg;

  localparam int EXP_W   = 8;
  localparam int IMANT_W = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_SCI = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREC      = 1'b1;

  localparam logic [2:0] PREC_MAX = 3'd4;

  localparam logic [6:0] CH_0     = 7'h30;
  localparam logic [6:0] CH_DOT   = 7'h2E;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_E     = 7'h65;

  typedef enum logic [1:0] {K_NUM, K_ZERO, K_INF, K_NAN} kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        neg;
    logic [62:0] mag;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SIGN, ST_SPEC, ST_PREP, ST_MUL, ST_RND, ST_CONV, ST_DIG,
    ST_DOT, ST_EXPE, ST_EXPM, ST_EXPD, ST_EXPT, ST_EXPU, ST_FIN
  } state_t;

  function automatic logic [63:0] up_pow(input logic [2:0] i);
    case (i)
      3'd0:    up_pow = 64'h4024000000000000;
      3'd1:    up_pow = 64'h4059000000000000;
      3'd2:    up_pow = 64'h40C3880000000000;
      3'd3:    up_pow = 64'h4197D78400000000;
      3'd4:    up_pow = 64'h4341C37937E08000;
      default: up_pow = 64'h4693B8B5B5056E17;
    endcase
  endfunction

  function automatic logic [63:0] down_pow(input logic [2:0] i);
    case (i)
      3'd0:    down_pow = 64'h3FB999999999999A;
      3'd1:    down_pow = 64'h3F847AE147AE147B;
      3'd2:    down_pow = 64'h3F1A36E2EB1C432D;
      3'd3:    down_pow = 64'h3E45798EE2308C3A;
      3'd4:    down_pow = 64'h3C9CD2B297D889BC;
      default: down_pow = 64'h3949F623D5A8A733;
    endcase
  endfunction

  // powers of ten as doubles, for window compares
  function automatic logic [63:0] dec_dbl(input logic [2:0] i);
    case (i)
      3'd0:    dec_dbl = 64'h3FF0000000000000;
      3'd1:    dec_dbl = 64'h4024000000000000;
      3'd2:    dec_dbl = 64'h4059000000000000;
      3'd3:    dec_dbl = 64'h408F400000000000;
      3'd4:    dec_dbl = 64'h40C3880000000000;
      default: dec_dbl = 64'h40F86A0000000000;
    endcase
  endfunction

  function automatic logic [IMANT_W-1:0] dec_int(input logic [2:0] i);
    case (i)
      3'd0:    dec_int = 17'd1;
      3'd1:    dec_int = 17'd10;
      3'd2:    dec_int = 17'd100;
      3'd3:    dec_int = 17'd1000;
      3'd4:    dec_int = 17'd10000;
      default: dec_int = 17'd100000;
    endcase
  endfunction

  function automatic logic [6:0] spec_char(input kind_t k, input logic [1:0] idx);
    logic [20:0] s;
    case (k)
      K_INF:   s = {7'h49, 7'h6E, 7'h66};
      K_NAN:   s = {7'h4E, 7'h61, 7'h4E};
      default: s = {CH_0, CH_DOT, CH_0};
    endcase
    case (idx)
      2'd0:    spec_char = s[20:14];
      2'd1:    spec_char = s[13:7];
      default: spec_char = s[6:0];
    endcase
  endfunction

endpackage

### hdl/dta_front.sv
// dta_front: accepts a raw double on start and classifies it for the queue.
// Depends on dta_pkg.
module dta_front (
  input  logic               start,
  input  logic               busy,
  input  logic [63:0]        value_bits,
  output logic               push,
  output dta_pkg::item_t     item
);
  import dta_pkg::*;

  logic [10:0] ex;
  logic        man_nz;

  assign ex     = value_bits[62:52];
  assign man_nz = |value_bits[51:0];
  assign push   = start && !busy;

  always_comb begin
    item.mag = value_bits[62:0];
    if (ex == 11'h7FF) begin
      item.kind = man_nz ? K_NAN : K_INF;
    end else if (ex == 11'd0) begin
      item.kind = K_ZERO;
    end else begin
      item.kind = K_NUM;
    end
    item.neg = value_bits[63] && !(ex == 11'h7FF && man_nz) && !(ex == 11'd0 && !man_nz);
  end

endmodule

### hdl/dta_fifo.sv
// dta_fifo: two-entry queue of classified items between front and back.
// Depends on dta_pkg.
module dta_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dta_pkg::item_t wr_item,
  input  logic           pop,
  output dta_pkg::item_t rd_item,
  output logic           full,
  output logic           empty
);
  import dta_pkg::*;

  item_t      mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign full    = count == 2'd2;
  assign empty   = count == 2'd0;
  assign rd_item = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### hdl/dta_back.sv
// dta_back: scales a classified double with an iterative double multiplier,
// extracts digits and emits the text one character per strobe beat, one value at a time. Depends on dta_pkg.
module dta_back #(
  parameter int SCALE_STEPS = 6
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           force_sci,
  input  logic [2:0]     prec_raw,
  input  logic           empty,
  input  dta_pkg::item_t rd_item,
  output logic           pop,
  output logic           strobe,
  output logic [6:0]     text_char,
  output logic           last_char
);
  import dta_pkg::*;

  localparam int IW = (SCALE_STEPS > 1) ? $clog2(SCALE_STEPS) : 1;

  state_t state, state_next;

  kind_t                    kind;
  logic                     neg;
  logic [62:0]              d;
  logic                     dir_up;
  logic [IW-1:0]            step;
  logic signed [EXP_W-1:0]  exponent;
  logic [2:0]               cnt;
  logic [53:0]              pp;
  logic [105:0]             acc;
  logic [IMANT_W-1:0]       imant;
  logic                     sci;
  logic [2:0]               point_at;
  logic [2:0]               pos;
  logic [3:0]               digit;
  logic                     suppress;
  logic [1:0]               spec_idx;
  logic [6:0]               emag;
  logic [3:0]               tens;
  logic                     pend_valid;
  logic [6:0]               pend_char;

  logic                     emit_en;
  logic [6:0]               emit_ch;

  logic [2:0]  prec;
  logic [63:0] lower_bits, upper_bits, cst;
  logic [52:0] ma, mb;
  logic [26:0] opx, opy;
  logic [105:0] addend;

  logic        hi, guard, sticky, lsb, rnd;
  logic [51:0] mfrac;
  logic [11:0] e_sum;
  logic [62:0] q;
  logic        accept;
  logic signed [EXP_W-1:0] delta;

  logic signed [EXP_W-1:0] exp_f;
  logic [10:0]             sh_full;
  logic [IMANT_W-1:0]      imant_c;
  logic                    sci_c;
  logic                    dig_ge;
  logic                    digits_done;

  assign prec       = (prec_raw > PREC_MAX) ? PREC_MAX : prec_raw;
  assign lower_bits = dec_dbl(prec);
  assign upper_bits = dec_dbl(prec + 3'd1);
  assign cst        = dir_up ? up_pow(3'(step)) : down_pow(3'(step));
  assign ma         = {1'b1, d[51:0]};
  assign mb         = {1'b1, cst[51:0]};

  // partial product order: lo*lo, hi*lo, lo*hi, hi*hi
  always_comb begin
    case (cnt[1:0])
      2'd0:    begin opx = ma[26:0];          opy = mb[26:0]; end
      2'd1:    begin opx = {1'b0, ma[52:27]}; opy = mb[26:0]; end
      2'd2:    begin opx = ma[26:0];          opy = {1'b0, mb[52:27]}; end
      default: begin opx = {1'b0, ma[52:27]}; opy = {1'b0, mb[52:27]}; end
    endcase
    case (cnt)
      3'd1:    addend = 106'(pp);
      3'd2,
      3'd3:    addend = 106'(pp) << 27;
      default: addend = 106'(pp) << 54;
    endcase
  end

  // round to nearest even
  always_comb begin
    hi     = acc[105];
    mfrac  = hi ? acc[104:53] : acc[103:52];
    guard  = hi ? acc[52] : acc[51];
    sticky = hi ? |acc[51:0] : |acc[50:0];
    lsb    = hi ? acc[53] : acc[52];
    rnd    = guard && (sticky || lsb);
    e_sum  = {1'b0, d[62:52]} + {1'b0, cst[62:52]} - 12'd1023 + 12'(hi);
    q      = {e_sum[10:0], mfrac} + 63'(rnd);
    accept = dir_up ? (q < upper_bits[62:0]) : (q >= lower_bits[62:0]);
    delta  = EXP_W'(1) <<< step;
  end

  always_comb begin
    exp_f   = exponent + EXP_W'(prec);
    sh_full = 11'd1075 - d[62:52];
    if (d >= upper_bits[62:0]) begin
      imant_c = dec_int(prec + 3'd1) - 17'd1;
    end else if (d[62:52] < 11'd1023) begin
      imant_c = '0;
    end else begin
      imant_c = IMANT_W'(ma >> sh_full[5:0]);
    end
    sci_c  = force_sci || (exp_f > $signed(EXP_W'(prec))) || (exp_f < 0);
    dig_ge = imant >= dec_int(pos);
    digits_done = suppress && (imant == '0);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (!empty) state_next = ST_SIGN;
      ST_SIGN: state_next = (kind == K_NUM) ? ST_PREP : ST_SPEC;
      ST_SPEC: if (spec_idx == 2'd2) state_next = ST_FIN;
      ST_PREP: state_next = ST_MUL;
      ST_MUL:  if (cnt == 3'd4) state_next = ST_RND;
      ST_RND:  state_next = (step == '0) ? ST_CONV : ST_MUL;
      ST_CONV: state_next = ST_DIG;
      ST_DIG: begin
        if (!dig_ge) begin
          if (digits_done || (pos != point_at && pos == 3'd0)) begin
            state_next = sci ? ST_EXPE : ST_FIN;
          end else if (pos == point_at) begin
            state_next = ST_DOT;
          end
        end
      end
      ST_DOT:  state_next = (pos == 3'd0) ? (sci ? ST_EXPE : ST_FIN) : ST_DIG;
      ST_EXPE: state_next = (exponent < 0) ? ST_EXPM : ST_EXPD;
      ST_EXPM: state_next = ST_EXPD;
      ST_EXPD: if (emag < 7'd10) state_next = (tens != 4'd0) ? ST_EXPT : ST_EXPU;
      ST_EXPT: state_next = ST_EXPU;
      ST_EXPU: state_next = ST_FIN;
      ST_FIN:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    emit_en = 1'b0;
    emit_ch = CH_0;
    pop     = 1'b0;
    unique case (state)
      ST_IDLE: pop = !empty;
      ST_SIGN: begin emit_en = neg; emit_ch = CH_MINUS; end
      ST_SPEC: begin emit_en = 1'b1; emit_ch = spec_char(kind, spec_idx); end
      ST_DIG:  begin emit_en = !dig_ge; emit_ch = CH_0 + 7'(digit); end
      ST_DOT:  begin emit_en = 1'b1; emit_ch = CH_DOT; end
      ST_EXPE: begin emit_en = 1'b1; emit_ch = CH_E; end
      ST_EXPM: begin emit_en = 1'b1; emit_ch = CH_MINUS; end
      ST_EXPT: begin emit_en = 1'b1; emit_ch = CH_0 + 7'(tens); end
      ST_EXPU: begin emit_en = 1'b1; emit_ch = CH_0 + emag; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        kind     <= rd_item.kind;
        neg      <= rd_item.neg;
        d        <= rd_item.mag;
        spec_idx <= 2'd0;
      end
      ST_SPEC: spec_idx <= spec_idx + 2'd1;
      ST_PREP: begin
        dir_up   <= d < lower_bits[62:0];
        step     <= IW'(SCALE_STEPS - 1);
        exponent <= '0;
        cnt      <= 3'd0;
      end
      ST_MUL: begin
        pp  <= 54'(opx) * 54'(opy);
        acc <= (cnt == 3'd0) ? '0 : acc + addend;
        cnt <= cnt + 3'd1;
      end
      ST_RND: begin
        if (accept) begin
          d        <= q;
          exponent <= dir_up ? exponent - delta : exponent + delta;
        end
        cnt <= 3'd0;
        if (step != '0) step <= step - IW'(1);
      end
      ST_CONV: begin
        exponent <= exp_f;
        imant    <= imant_c;
        sci      <= sci_c;
        point_at <= sci_c ? prec : prec - exp_f[2:0];
        pos      <= prec;
        digit    <= 4'd0;
        suppress <= 1'b0;
      end
      ST_DIG: begin
        if (dig_ge) begin
          imant <= imant - dec_int(pos);
          digit <= digit + 4'd1;
        end else if (!digits_done && pos != point_at && pos != 3'd0) begin
          pos   <= pos - 3'd1;
          digit <= 4'd0;
        end
      end
      ST_DOT: begin
        suppress <= 1'b1;
        if (pos != 3'd0) begin
          pos   <= pos - 3'd1;
          digit <= 4'd0;
        end
      end
      ST_EXPE: begin
        emag <= (exponent < 0) ? 7'(-exponent) : 7'(exponent);
        tens <= 4'd0;
      end
      ST_EXPD: begin
        if (emag >= 7'd10) begin
          emag <= emag - 7'd10;
          tens <= tens + 4'd1;
        end
      end
      default: ;
    endcase
  end

  // one-character hold so the final beat can carry last_char
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe     <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (state == ST_FIN) begin
        strobe     <= 1'b1;
        text_char  <= pend_char;
        last_char  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (emit_en) begin
        if (pend_valid) begin
          strobe    <= 1'b1;
          text_char <= pend_char;
          last_char <= 1'b0;
        end
        pend_char  <= emit_ch;
        pend_valid <= 1'b1;
      end
    end
  end

  a_fin_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |=> (strobe && last_char))
    else $error("final beat not marked");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("held character left over at idle");

  a_fin_has_char: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |-> pend_valid)
    else $error("finish with no character held");

  a_mul_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (cnt <= 3'd4))
    else $error("partial product count out of range");

endmodule

### hdl/double_to_ascii_formatter_top.sv
// double_to_ascii_formatter_top: config registers, classifier, queue and back end.
// Depends on dta_pkg, dta_front, dta_fifo, dta_back.
// For finite values the back end scales the double in six steps (SCALE_STEPS=6) on one 27x27
// multiplier, each step summing four partial products and rounding, then runs the digit
// loop, which subtracts the place value once per unit of each digit; Inf/NaN/zero take a short path.
// The back end takes the next value from the queue only after finishing the current one.
// busy is high only while the two-entry queue is full.
// Synchronous reset: force_scientific=1, digit_precision=2, queue empty. Output cannot stall.
module double_to_ascii_formatter_top #(
  parameter int SCALE_STEPS = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [63:0]                   value_bits,
  input  logic                          cfg_we,
  input  logic [dta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dta_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                          strobe,
  output logic [6:0]                    text_char,
  output logic                          last_char
);
  import dta_pkg::*;

  logic       force_scientific;
  logic [2:0] digit_precision;
  logic       push, pop, empty;
  item_t      wr_item, rd_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      force_scientific <= 1'b1;
      digit_precision  <= 3'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FORCE_SCI: force_scientific <= cfg_data[0];
        CFG_PREC:      digit_precision  <= cfg_data;
        default: ;
      endcase
    end
  end

  dta_front u_front (
    .start      (start),
    .busy       (busy),
    .value_bits (value_bits),
    .push       (push),
    .item       (wr_item)
  );

  dta_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .full    (busy),
    .empty   (empty)
  );

  dta_back #(.SCALE_STEPS(SCALE_STEPS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .force_sci (force_scientific),
    .prec_raw  (digit_precision),
    .empty     (empty),
    .rd_item   (rd_item),
    .pop       (pop),
    .strobe    (strobe),
    .text_char (text_char),
    .last_char (last_char)
  );

endmodule
